### hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic               enq;
        logic               deq;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } t_cmd;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
        logic               spill;   // entry moves one place towards the tail
    } t_link;

endpackage

### hw/rtl/spq_if.sv
interface spq_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [spq_pkg::VALUE_W-1:0]  item_value;
    logic        [spq_pkg::PRIO_W-1:0]   item_priority;

    modport source (output valid, kind, item_value, item_priority, input ready);
    modport sink   (input valid, kind, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [spq_pkg::VALUE_W-1:0]  out_value;
    logic        [1:0]                   status;
    logic        [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, out_value, status, occupancy, input ready);
    modport sink   (input valid, out_value, status, occupancy, output ready);
endinterface

### hw/rtl/spq_cell.sv
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cmd  i_cmd,
    input  spq_pkg::t_link i_left,
    input  spq_pkg::t_link i_right,
    output spq_pkg::t_link o_link
);

    logic                        r_valid;
    logic [spq_pkg::VALUE_W-1:0] r_value;
    logic [spq_pkg::PRIO_W-1:0]  r_prio;
    logic                        n_valid;
    logic [spq_pkg::VALUE_W-1:0] n_value;
    logic [spq_pkg::PRIO_W-1:0]  n_prio;
    logic                        w_yield;

    // own entry gives way to the new one (ties: newest first)
    assign w_yield = r_valid && (r_prio <= i_cmd.prio);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.enq) begin
            if (i_left.spill) begin
                n_valid = 1'b1;
                n_value = i_left.value;
                n_prio  = i_left.prio;
            end else if (i_left.valid && (!r_valid || w_yield)) begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
                n_prio  = i_cmd.prio;
            end
        end else if (i_cmd.deq) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
            n_prio  = i_right.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_link.valid = r_valid;
    assign o_link.value = r_value;
    assign o_link.prio  = r_prio;
    assign o_link.spill = w_yield;

endmodule

### hw/rtl/sorted_priority_queue_top.sv
// Sorted priority queue: a chain of compare-and-shift cells, head at cell 0.
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle unless a result beat is stalled; every
// cell decides insert, shift or hold in parallel from the broadcast operation.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// stored payloads are not cleared, only the per-cell valid bits.
module sorted_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Chain of cells
    spq_pkg::t_cmd  w_cmd;
    spq_pkg::t_link w_link [CAPACITY];
    spq_pkg::t_link w_head_left;   // sentinel ahead of the head: always keeps
    spq_pkg::t_link w_tail_right;  // sentinel behind the tail: empty

    // Occupancy and result register
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    logic [spq_pkg::VALUE_W-1:0]  r_out_value;
    spq_pkg::t_status             r_status;
    logic [spq_pkg::OCC_W-1:0]    r_occ;
    logic [spq_pkg::VALUE_W-1:0]  n_out_value;
    spq_pkg::t_status             n_status;
    logic [CNT_W+spq_pkg::OCC_W-1:0] w_occ_ext;

    logic w_fire;
    logic w_is_enq;
    logic w_full;
    logic w_empty;

    // A new beat is taken while the result register is free or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_is_enq   = (spq_pkg::t_kind'(i_in.kind) == spq_pkg::KIND_ENQ);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // Full enqueues and empty dequeues leave the chain untouched.
    assign w_cmd.enq   = w_fire && w_is_enq && !w_full;
    assign w_cmd.deq   = w_fire && !w_is_enq && !w_empty;
    assign w_cmd.value = i_in.item_value;
    assign w_cmd.prio  = i_in.item_priority;

    assign w_head_left.valid  = 1'b1;
    assign w_head_left.value  = '0;
    assign w_head_left.prio   = '0;
    assign w_head_left.spill  = 1'b0;
    assign w_tail_right.valid = 1'b0;
    assign w_tail_right.value = '0;
    assign w_tail_right.prio  = '0;
    assign w_tail_right.spill = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_link w_left;
        spq_pkg::t_link w_right;
        if (g == 0) begin : g_head
            assign w_left = w_head_left;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_tail_right;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end
        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    // Result of the beat being accepted, taken from the head before the shift.
    always_comb begin
        n_count     = r_count;
        n_out_value = '0;
        n_status    = spq_pkg::ST_OK;
        if (w_is_enq) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count     = r_count - CNT_W'(1);
                n_out_value = w_link[0].value;
            end
        end
    end

    // Occupancy carries the low five bits of the count.
    assign w_occ_ext = {{spq_pkg::OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_fire) begin
            r_out_value <= n_out_value;
            r_status    <= n_status;
            r_occ       <= w_occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.status    = r_status;
    assign o_out.occupancy = r_occ;

endmodule

### hw/rtl/spq_checker.sv
module spq_checker #(
    parameter int CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic [1:0]  i_status,
    input logic [4:0]  i_occupancy
);

    localparam logic [4:0] CAP_OCC = 5'(CAPACITY);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_value) && $stable(i_occupancy))
        else $error("result beat changed while stalled");

    // each accepted beat yields a result beat next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted beat gave no result");

    // an empty dequeue reports zero entries and a zero value
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == spq_pkg::ST_EMPTY |-> i_occupancy == 5'd0
            && i_out_value == 32'd0)
        else $error("empty status with entries or value");

    // a dropped enqueue only happens at full capacity
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == spq_pkg::ST_FULL |-> i_occupancy == CAP_OCC
            && i_out_value == 32'd0)
        else $error("full status below capacity");

endmodule

bind sorted_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.out_value),
    .i_status    (o_out.status),
    .i_occupancy (o_out.occupancy)
);

### bench/tb_sorted_priority_queue_top.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue_top;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 300;    // long receiver stall, fills the pipeline
    localparam int N_PHASE_A   = 600;    // sender idles lightly, receiver heavily
    localparam int N_PHASE_B   = 600;    // the other way round
    localparam int N_PHASE_C   = 676;    // no idling apart from the long stall

    logic i_clk;
    logic i_rst_n;

    spq_in_if  in_if ();
    spq_out_if out_if ();

    sorted_priority_queue_top #(.CAPACITY(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the queue plus the list of result beats still owed.
    // Entries are held sorted, head at index 0; a push goes ahead of every
    // entry with a priority less than or equal to its own.
    // ------------------------------------------------------------------
    class queue_scoreboard;
        typedef struct {
            logic signed [spq_pkg::VALUE_W-1:0] value;
            spq_pkg::t_status                   status;
            logic [spq_pkg::OCC_W-1:0]          occupancy;
        } t_result;

        logic signed [spq_pkg::VALUE_W-1:0] held_value [DEPTH];
        logic [spq_pkg::PRIO_W-1:0]         held_prio  [DEPTH];
        int unsigned               held;
        t_result                   owed_results[$];
        int unsigned               errors;
        int unsigned               n_push, n_pop, n_pop_empty, n_push_full, n_checked;
        int unsigned               peak;

        function new();
            held = 0;
            errors = 0;
            n_push = 0;
            n_pop = 0;
            n_pop_empty = 0;
            n_push_full = 0;
            n_checked = 0;
            peak = 0;
        endfunction

        // Apply one accepted operation to the shadow and queue up its result.
        function void note_op(spq_pkg::t_kind k, logic signed [spq_pkg::VALUE_W-1:0] v,
                              logic [spq_pkg::PRIO_W-1:0] p);
            t_result r;
            int unsigned pos;
            r.value = '0;
            r.status = spq_pkg::ST_OK;
            if (k == spq_pkg::KIND_ENQ) begin
                if (held >= DEPTH) begin
                    r.status = spq_pkg::ST_FULL;
                    n_push_full++;
                end else begin
                    pos = 0;
                    while (pos < held && held_prio[pos] > p)
                        pos++;
                    for (int j = held; j > pos; j--) begin
                        held_value[j] = held_value[j-1];
                        held_prio[j]  = held_prio[j-1];
                    end
                    held_value[pos] = v;
                    held_prio[pos]  = p;
                    held++;
                    n_push++;
                end
            end else if (held == 0) begin
                r.status = spq_pkg::ST_EMPTY;
                n_pop_empty++;
            end else begin
                r.value = held_value[0];
                for (int j = 1; j < held; j++) begin
                    held_value[j-1] = held_value[j];
                    held_prio[j-1]  = held_prio[j];
                end
                held--;
                n_pop++;
            end
            if (held > peak)
                peak = held;
            r.occupancy = held[spq_pkg::OCC_W-1:0];
            owed_results.push_back(r);
        endfunction

        function void check_result(logic signed [spq_pkg::VALUE_W-1:0] v, logic [1:0] st,
                                   logic [spq_pkg::OCC_W-1:0] occ);
            t_result r;
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: out_value %0d status %0d occupancy %0d",
                       v, st, occ);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            n_checked++;
            if (v !== r.value) begin
                $error("out_value: expected %0d, got %0d", r.value, v);
                errors++;
            end
            if (st !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (occ !== r.occupancy) begin
                $error("occupancy: expected %0d, got %0d", r.occupancy, occ);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function void report_leftover();
            foreach (owed_results[i]) begin
                $error("result never arrived: out_value %0d status %0d occupancy %0d",
                       owed_results[i].value, owed_results[i].status,
                       owed_results[i].occupancy);
                errors++;
            end
        endfunction
    endclass

    queue_scoreboard board = new();

    // Idle percentages per side, changed between phases
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    // Long receiver stall: requested by the stimulus, counted down here
    logic        hold_req;
    logic        hold_done;
    int unsigned hold_left;
    logic        rx_hold;
    int unsigned cycles;

    assign rx_hold = (hold_left != 0);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hold-off counter; sampled at posedge so the receiver sees a stable value
    // when it updates ready on the falling edge.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: ready moves only on the falling edge
    always @(negedge i_clk) begin
        out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Both handshakes are seen in one process, input first, so a beat's
    // expectation is always in place before its result could be checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                board.note_op(spq_pkg::t_kind'(in_if.kind), in_if.item_value,
                              in_if.item_priority);
            if (out_if.valid && out_if.ready)
                board.check_result(out_if.out_value, out_if.status, out_if.occupancy);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.pending());
            $display("tb_sorted_priority_queue_top: done, errors");
            $finish;
        end
    end

    // Offer one beat, starting at a falling edge. Valid is only lowered during
    // an idle gap, so a back-to-back beat never sees valid dropped and raised
    // in the same step.
    task automatic send_op(input spq_pkg::t_kind k,
                           input logic signed [spq_pkg::VALUE_W-1:0] v,
                           input logic [spq_pkg::PRIO_W-1:0] p);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.kind          <= k;
        in_if.item_value    <= v;
        in_if.item_priority <= p;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_push(input logic signed [spq_pkg::VALUE_W-1:0] v,
                             input logic [spq_pkg::PRIO_W-1:0] p);
        send_op(spq_pkg::KIND_ENQ, v, p);
    endtask

    // Pop beats carry random junk in the ignored fields
    task automatic send_pop();
        send_op(spq_pkg::KIND_DEQ, $urandom, 8'($urandom_range(255)));
    endtask

    // Random traffic in bursts. Each burst leans towards filling, draining or
    // hovering, so the queue swings between empty and full over and over.
    // Priorities often come from a narrow band to get plenty of ties.
    task automatic random_traffic(input int unsigned n_items);
        int unsigned done_items;
        int unsigned burst_len;
        int unsigned push_pct;
        int unsigned band;
        logic signed [spq_pkg::VALUE_W-1:0] v;
        logic [spq_pkg::PRIO_W-1:0] p;
        done_items = 0;
        while (done_items < n_items) begin
            burst_len = $urandom_range(60, 10);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 20;
                default: push_pct = 55;
            endcase
            band = $urandom_range(252);
            for (int i = 0; i < burst_len && done_items < n_items; i++) begin
                if ($urandom_range(99) < push_pct) begin
                    case ($urandom_range(15))
                        0: v = 32'sh7FFF_FFFF;
                        1: v = 32'sh8000_0000;
                        2: v = '0;
                        default: v = $urandom;
                    endcase
                    if ($urandom_range(2) == 0)
                        p = 8'(band + $urandom_range(3));
                    else
                        p = 8'($urandom_range(255));
                    send_push(v, p);
                end else begin
                    send_pop();
                end
                done_items++;
            end
        end
    endtask

    initial begin
        // Every input known from time zero
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.kind          = spq_pkg::KIND_ENQ;
        in_if.item_value    = '0;
        in_if.item_priority = '0;
        out_if.ready        = 1'b0;
        hold_req            = 1'b0;
        hold_done           = 1'b0;
        hold_left           = 0;
        cycles              = 0;
        tx_idle_pct         = 0;
        rx_idle_pct         = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening, run with no idling.
        // Pop from an empty queue.
        send_pop();
        // Fill to capacity: extremes of value and priority, a run of ties at
        // 128 (newest must come out first), walking bit patterns.
        send_push(32'sh7FFF_FFFF, 8'd255);
        send_push(32'sh8000_0000, 8'd0);
        send_push(32'sd0,         8'd128);
        send_push(-32'sd1,        8'd128);
        send_push(32'sd1,         8'd128);
        send_push(32'sh5555_5555, 8'h55);
        send_push(32'shAAAA_AAAA, 8'hAA);
        send_push(32'sh0F0F_0F0F, 8'd255);
        send_push(32'shF0F0_F0F0, 8'd0);
        send_push(32'sh1234_5678, 8'h01);
        send_push(32'sh8765_4321, 8'hFE);
        send_push(32'sh0000_FFFF, 8'h80);
        send_push(32'shFFFF_0000, 8'h7F);
        send_push(32'sh3333_3333, 8'd128);
        send_push(32'shCCCC_CCCC, 8'h0F);
        send_push(32'sh0101_0101, 8'hF0);
        // Sixteen held; this one is refused
        send_push(32'sh7777_7777, 8'd255);
        // Take a few off the head
        repeat (6) send_pop();

        // Phase A: sender 35%, receiver 76%
        tx_idle_pct = 35;
        rx_idle_pct = 76;
        random_traffic(N_PHASE_A);

        // Phase B: swapped
        tx_idle_pct = 76;
        rx_idle_pct = 35;
        random_traffic(N_PHASE_B);

        // Phase C: no idling; early on the receiver stalls for a long stretch
        // while the sender keeps offering, so the block backs up and stalls
        // its input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        random_traffic(N_PHASE_C);

        in_if.valid <= 1'b0;

        // Drain, then keep clocking the idle pipeline to give it room to misbehave
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        board.report_leftover();
        $display("covered %0d pushes, %0d pops, %0d pops on an empty queue,",
                 board.n_push, board.n_pop, board.n_pop_empty);
        $display("%0d pushes refused when full, peak depth %0d, %0d result beats checked",
                 board.n_push_full, board.peak, board.n_checked);
        if (board.errors == 0) begin
            $display("tb_sorted_priority_queue_top: done, clean");
        end else begin
            $display("tb_sorted_priority_queue_top: done, errors");
        end
        $finish;
    end

endmodule
